[design/mds_pkg.sv]
// Shared constants, types and the digit code table of the digit scanner.
package mds_pkg;

   localparam int TUBE_COUNT = 6;
   localparam int SLOT_W     = 3;
   localparam int DIGIT_W    = 4;
   localparam int TICK_W     = 16;
   localparam int DUTY_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   localparam logic [DIGIT_W-1:0] BLANK_CODE = 4'd15;
   localparam logic [SLOT_W-1:0]  SCAN_RESET = SLOT_W'(4 % TUBE_COUNT);
   localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(TUBE_COUNT - 1);

   localparam logic [TICK_W-1:0]  ON_TICKS_RESET    = 16'd4;
   localparam logic [TICK_W-1:0]  OFF_TICKS_RESET   = 16'd1;
   localparam logic [TICK_W-1:0]  BLANK_TICKS_RESET = 16'd5;
   localparam logic [DUTY_W-1:0]  BRIGHTNESS_RESET  = 8'd255;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_ON_TICKS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_TICKS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLANK_TICKS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS  = 2'd3;

   // action codes carried on tuser
   localparam logic ACT_TICK  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   typedef struct packed {
      logic [SLOT_W-1:0]  anode_select;
      logic [DUTY_W-1:0]  anode_duty;
      logic [DIGIT_W-1:0] cathode_code;
   } drive_type;

   // remap a decimal digit to its cathode code, anything above nine is blank
   function automatic logic [DIGIT_W-1:0] digit_to_code(input logic [DIGIT_W-1:0] number);
      logic [DIGIT_W-1:0] code;
      unique case (number)
         4'd0:    code = 4'd1;
         4'd1:    code = 4'd0;
         4'd2:    code = 4'd9;
         4'd3:    code = 4'd8;
         4'd4:    code = 4'd7;
         4'd5:    code = 4'd6;
         4'd6:    code = 4'd5;
         4'd7:    code = 4'd4;
         4'd8:    code = 4'd3;
         4'd9:    code = 4'd2;
         default: code = BLANK_CODE;
      endcase
      return code;
   endfunction

endpackage

[design/multiplexed_digit_scanner.sv]
// Top level of the multiplexed digit scanner: input stage, scan logic, result stage.
// Path: a word accepted into the input register passes the scan logic into the result
//   register, which drives rsp_; it moves on only while the result register is free or drained.
// Throughput: one word per clock while the receiver keeps the result register draining; the scan
//   update (one 16-bit decrement/compare and a six-way slot mux) sets that figure.
// Reset (synchronous, active high): all slots blank, scan at tube 4, tube dark,
//   wait counter zero, configuration at on 4, off 1, blank 5, brightness 255.
module multiplexed_digit_scanner (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [mds_pkg::REQ_DATA_W-1:0]       req_tdata,  // [2:0] digit_slot, [6:3] digit_number
   input  logic                                 req_tuser,  // [0] action
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mds_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // [2:0] anode_select,
                                                            // [10:3] anode_duty,
                                                            // [14:11] cathode_code
   // configuration writes
   input  logic                                 csr_we,
   input  logic [mds_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mds_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // configuration registers
   logic [mds_pkg::TICK_W-1:0]  on_ticks_ff;
   logic [mds_pkg::TICK_W-1:0]  off_ticks_ff;
   logic [mds_pkg::TICK_W-1:0]  blank_ticks_ff;
   logic [mds_pkg::DUTY_W-1:0]  brightness_ff;

   // input stage
   logic                         in_valid_ff;
   logic                         in_action_ff;
   logic [mds_pkg::SLOT_W-1:0]   in_slot_ff;
   logic [mds_pkg::DIGIT_W-1:0]  in_number_ff;
   logic                         in_advance;

   // scanner state
   logic [mds_pkg::DIGIT_W-1:0]  slot_codes_ff [mds_pkg::TUBE_COUNT];
   logic [mds_pkg::SLOT_W-1:0]   scan_position_ff, scan_position_in;
   logic                         tube_lit_ff, tube_lit_in;
   logic [mds_pkg::TICK_W-1:0]   wait_count_ff, wait_count_in;
   logic [mds_pkg::DIGIT_W-1:0]  drive_code_ff, drive_code_in;
   logic [mds_pkg::DUTY_W-1:0]   drive_duty_ff, drive_duty_in;

   // result stage
   logic                         out_valid_ff;
   mds_pkg::drive_type           out_drive_ff;

   logic [mds_pkg::SLOT_W-1:0]   scan_next;
   logic [mds_pkg::DIGIT_W-1:0]  cur_code;
   logic                         slot_write;

   // ------------------------------------------------------------------
   // Configuration: take a write whenever the enable is high
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         on_ticks_ff    <= mds_pkg::ON_TICKS_RESET;
         off_ticks_ff   <= mds_pkg::OFF_TICKS_RESET;
         blank_ticks_ff <= mds_pkg::BLANK_TICKS_RESET;
         brightness_ff  <= mds_pkg::BRIGHTNESS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            mds_pkg::CSR_ON_TICKS:    on_ticks_ff    <= csr_wdata;
            mds_pkg::CSR_OFF_TICKS:   off_ticks_ff   <= csr_wdata;
            mds_pkg::CSR_BLANK_TICKS: blank_ticks_ff <= csr_wdata;
            mds_pkg::CSR_BRIGHTNESS:  brightness_ff  <= csr_wdata[mds_pkg::DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Handshake: the input word moves on whenever the result register is
   // empty or being drained, so a new word can enter every cycle while that holds.
   // ------------------------------------------------------------------
   assign in_advance = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || in_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_action_ff <= req_tuser;
         in_slot_ff   <= req_tdata[mds_pkg::SLOT_W-1:0];
         in_number_ff <= req_tdata[mds_pkg::SLOT_W +: mds_pkg::DIGIT_W];
      end
   end

   // ------------------------------------------------------------------
   // Scan logic
   // ------------------------------------------------------------------
   assign scan_next  = (scan_position_ff == mds_pkg::LAST_SLOT) ?
                       '0 : scan_position_ff + 1'b1;
   assign cur_code   = slot_codes_ff[scan_position_ff];
   // drop writes to slots past the last tube
   assign slot_write = in_advance && (in_action_ff == mds_pkg::ACT_WRITE) &&
                       (in_slot_ff <= mds_pkg::LAST_SLOT);

   always_comb begin
      scan_position_in = scan_position_ff;
      tube_lit_in      = tube_lit_ff;
      wait_count_in    = wait_count_ff;
      drive_code_in    = drive_code_ff;
      drive_duty_in    = drive_duty_ff;
      if (in_action_ff == mds_pkg::ACT_TICK) begin
         priority if (wait_count_ff > mds_pkg::TICK_W'(1)) begin
            // still waiting: count down
            wait_count_in = wait_count_ff - 1'b1;
         end else if (tube_lit_ff) begin
            // lit tube: go dark, advance, hold the gap
            drive_duty_in    = '0;
            tube_lit_in      = 1'b0;
            scan_position_in = scan_next;
            wait_count_in    = off_ticks_ff;
         end else if (cur_code == mds_pkg::BLANK_CODE) begin
            // blank slot: stay dark, cathode code holds its last value
            drive_duty_in    = '0;
            scan_position_in = scan_next;
            wait_count_in    = blank_ticks_ff;
         end else begin
            // light the slot at the brightness in force now
            drive_code_in = cur_code;
            drive_duty_in = brightness_ff;
            tube_lit_in   = 1'b1;
            wait_count_in = on_ticks_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_position_ff <= mds_pkg::SCAN_RESET;
         tube_lit_ff      <= 1'b0;
         wait_count_ff    <= '0;
         drive_code_ff    <= '0;
         drive_duty_ff    <= '0;
         for (int i = 0; i < mds_pkg::TUBE_COUNT; i++) begin
            slot_codes_ff[i] <= mds_pkg::BLANK_CODE;
         end
      end else begin
         if (in_advance) begin
            scan_position_ff <= scan_position_in;
            tube_lit_ff      <= tube_lit_in;
            wait_count_ff    <= wait_count_in;
            drive_code_ff    <= drive_code_in;
            drive_duty_ff    <= drive_duty_in;
         end
         if (slot_write) begin
            slot_codes_ff[in_slot_ff] <= mds_pkg::digit_to_code(in_number_ff);
         end
      end
   end

   // ------------------------------------------------------------------
   // Result register: every word yields the drive after its update
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (in_advance) begin
         out_drive_ff.anode_select <= scan_position_in;
         out_drive_ff.anode_duty   <= drive_duty_in;
         out_drive_ff.cathode_code <= drive_code_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_drive_ff.cathode_code, out_drive_ff.anode_duty,
                        out_drive_ff.anode_select};

endmodule

[test/mds_drive_checker.sv]
`timescale 1ns / 1ps
// Scoreboard of the digit scanner: tracks the scan, queues expected drive words, compares them.
module mds_drive_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [mds_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                          req_tuser,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [mds_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                          csr_we,
   input  logic [mds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mds_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                            fail_count,
   output int                            outstanding
);

   logic [mds_pkg::TICK_W-1:0]  on_ticks, off_ticks, blank_ticks, wait_left;
   logic [mds_pkg::DUTY_W-1:0]  brightness, duty_now;
   logic [mds_pkg::DIGIT_W-1:0] code_now;
   logic [mds_pkg::DIGIT_W-1:0] slot_code [mds_pkg::TUBE_COUNT];
   logic [mds_pkg::SLOT_W-1:0]  scan_pos;
   logic                        tube_on;
   mds_pkg::drive_type          drive_queue [$];
   int                          errors = 0;

   // apply one word to the scan state and return the drive it leaves behind
   task automatic step_scanner(input logic act, input logic [mds_pkg::SLOT_W-1:0] slot,
                               input logic [mds_pkg::DIGIT_W-1:0] number,
                               output mds_pkg::drive_type drv);
      logic [mds_pkg::SLOT_W-1:0] next_pos;
      next_pos = (scan_pos == mds_pkg::LAST_SLOT) ? '0 : scan_pos + 1'b1;
      if (act == mds_pkg::ACT_WRITE) begin
         if (slot < mds_pkg::TUBE_COUNT) begin
            if (number > 9)
               slot_code[slot] = mds_pkg::BLANK_CODE;
            else if (number < 2)
               slot_code[slot] = {3'b000, ~number[0]};
            else
               slot_code[slot] = 4'd11 - number;
         end
      end else if (wait_left > 1) begin
         wait_left = wait_left - 1'b1;
      end else if (tube_on) begin
         duty_now  = '0;
         tube_on   = 1'b0;
         scan_pos  = next_pos;
         wait_left = off_ticks;
      end else if (slot_code[scan_pos] == mds_pkg::BLANK_CODE) begin
         duty_now  = '0;
         scan_pos  = next_pos;
         wait_left = blank_ticks;
      end else begin
         code_now  = slot_code[scan_pos];
         duty_now  = brightness;
         tube_on   = 1'b1;
         wait_left = on_ticks;
      end
      drv.anode_select = scan_pos;
      drv.anode_duty   = duty_now;
      drv.cathode_code = code_now;
   endtask

   always @(posedge clock) begin : track
      mds_pkg::drive_type want, got;
      if (reset) begin
         on_ticks    = mds_pkg::ON_TICKS_RESET;
         off_ticks   = mds_pkg::OFF_TICKS_RESET;
         blank_ticks = mds_pkg::BLANK_TICKS_RESET;
         brightness  = mds_pkg::BRIGHTNESS_RESET;
         for (int i = 0; i < mds_pkg::TUBE_COUNT; i++)
            slot_code[i] = mds_pkg::BLANK_CODE;
         scan_pos  = mds_pkg::SCAN_RESET;
         tube_on   = 1'b0;
         wait_left = '0;
         code_now  = '0;
         duty_now  = '0;
         drive_queue.delete();
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               mds_pkg::CSR_ON_TICKS:    on_ticks    = csr_wdata;
               mds_pkg::CSR_OFF_TICKS:   off_ticks   = csr_wdata;
               mds_pkg::CSR_BLANK_TICKS: blank_ticks = csr_wdata;
               mds_pkg::CSR_BRIGHTNESS:  brightness  = csr_wdata[mds_pkg::DUTY_W-1:0];
               default: ;
            endcase
         end
         // results leave the block behind its input and result registers, so retire before queuing
         if (rsp_tvalid && rsp_tready) begin
            got.anode_select = rsp_tdata[mds_pkg::SLOT_W-1:0];
            got.anode_duty   = rsp_tdata[mds_pkg::SLOT_W +: mds_pkg::DUTY_W];
            got.cathode_code = rsp_tdata[mds_pkg::SLOT_W+mds_pkg::DUTY_W +: mds_pkg::DIGIT_W];
            if (drive_queue.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected drive word: select %0d duty %0d code %0d",
                           got.anode_select, got.anode_duty, got.cathode_code);
            end else begin
               want = drive_queue.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("drive mismatch (select duty code): expected %0d %0d %0d, got %0d %0d %0d",
                              want.anode_select, want.anode_duty, want.cathode_code,
                              got.anode_select, got.anode_duty, got.cathode_code);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            step_scanner(req_tuser, req_tdata[mds_pkg::SLOT_W-1:0],
                         req_tdata[mds_pkg::SLOT_W +: mds_pkg::DIGIT_W], want);
            drive_queue.push_back(want);
         end
      end
      fail_count  <= errors;
      outstanding <= drive_queue.size();
   end

endmodule

[test/multiplexed_digit_scanner_tb.sv]
`timescale 1ns / 1ps
// Testbench top of the digit scanner: clock, reset, phased stimulus and the verdict.
module multiplexed_digit_scanner_tb;

   // cycle limit for the whole run, with a wide margin over what the phases need
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_WORDS = 400;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [mds_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;  // [2:0] digit_slot, [6:3] digit_number
   logic                             req_tuser  = mds_pkg::ACT_TICK;  // [0] action
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [mds_pkg::RSP_DATA_W-1:0]   rsp_tdata;  // [2:0] anode_select, [10:3] anode_duty,
                                                 // [14:11] cathode_code
   logic                             csr_we     = 1'b0;
   logic [mds_pkg::CSR_IDX_W-1:0]    csr_index  = mds_pkg::CSR_ON_TICKS;
   logic [mds_pkg::CSR_DATA_W-1:0]   csr_wdata  = '0;

   int idle_pct    = 0;   // chance per cycle that the sender holds off
   int stall_pct   = 0;   // chance per cycle that the receiver drops tready
   int cycle_count = 0;
   int fail_count;
   int outstanding;

   multiplexed_digit_scanner u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   mds_drive_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // receiver: drop tready at random, rate set per phase
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // hang guard: a stuck handshake or a lost result ends here
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   // offer one word, with a random hold-off first, and return at the edge that takes it;
   // valid stays high into the next call when no hold-off is drawn
   task automatic send_word(input logic act, input logic [mds_pkg::SLOT_W-1:0] slot,
                            input logic [mds_pkg::DIGIT_W-1:0] number);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {1'b0, number, slot};
      do @(posedge clock); while (!req_tready);
   endtask

   // drop valid and drain: every word yields a result, so an empty queue means idle,
   // the extra edges cover the two-stage pipe
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   // write all four registers on back-to-back edges, hold we high across them
   task automatic configure(input logic [mds_pkg::CSR_DATA_W-1:0] on_val,
                            input logic [mds_pkg::CSR_DATA_W-1:0] off_val,
                            input logic [mds_pkg::CSR_DATA_W-1:0] blank_val,
                            input logic [mds_pkg::CSR_DATA_W-1:0] bright_val);
      csr_we    <= 1'b1;
      csr_index <= mds_pkg::CSR_ON_TICKS;
      csr_wdata <= on_val;
      @(posedge clock);
      csr_index <= mds_pkg::CSR_OFF_TICKS;
      csr_wdata <= off_val;
      @(posedge clock);
      csr_index <= mds_pkg::CSR_BLANK_TICKS;
      csr_wdata <= blank_val;
      @(posedge clock);
      csr_index <= mds_pkg::CSR_BRIGHTNESS;
      csr_wdata <= bright_val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // one phase: reconfigure while idle, set the idling mix, then random words,
   // mostly ticks so the scan keeps moving, with enough writes to churn the slots
   task automatic run_phase(input logic [mds_pkg::CSR_DATA_W-1:0] on_val,
                            input logic [mds_pkg::CSR_DATA_W-1:0] off_val,
                            input logic [mds_pkg::CSR_DATA_W-1:0] blank_val,
                            input logic [mds_pkg::CSR_DATA_W-1:0] bright_val,
                            input int send_idle, input int recv_stall, input int words);
      settle();
      configure(on_val, off_val, blank_val, bright_val);
      idle_pct  = send_idle;
      stall_pct = recv_stall;
      for (int n = 0; n < words; n++) begin
         send_word(($urandom_range(99) < 20) ? mds_pkg::ACT_WRITE : mds_pkg::ACT_TICK,
                   mds_pkg::SLOT_W'($urandom_range(7)),
                   mds_pkg::DIGIT_W'($urandom_range(15)));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset timing, every digit extreme, blank codes, out-of-range slots
      send_word(mds_pkg::ACT_TICK, 3'd0, 4'd0);     // first tick steps off the blank reset slot
      send_word(mds_pkg::ACT_WRITE, 3'd0, 4'd0);
      send_word(mds_pkg::ACT_WRITE, 3'd1, 4'd1);
      send_word(mds_pkg::ACT_WRITE, 3'd2, 4'd2);
      send_word(mds_pkg::ACT_WRITE, 3'd3, 4'd9);
      send_word(mds_pkg::ACT_WRITE, 3'd4, 4'd8);
      send_word(mds_pkg::ACT_WRITE, 3'd5, 4'd10);   // ten stores blank
      send_word(mds_pkg::ACT_WRITE, 3'd6, 4'd3);    // slot past the last tube, dropped
      send_word(mds_pkg::ACT_WRITE, 3'd7, 4'd15);   // same, all ones in both fields
      repeat (10) send_word(mds_pkg::ACT_TICK, 3'd7, 4'd15);
      send_word(mds_pkg::ACT_WRITE, 3'd0, 4'd15);   // above ten also stores blank
      send_word(mds_pkg::ACT_WRITE, 3'd2, 4'd12);
      repeat (4) send_word(mds_pkg::ACT_TICK, 3'd0, 4'd0);

      // zero delays act as one, brightness floor, sender mostly idle
      run_phase(16'd0, 16'd0, 16'd0, 16'h0000, 82, 0, PHASE_WORDS);
      // short delays, mixed duty bits, receiver mostly stalled
      run_phase(16'd3, 16'd2, 16'd1, 16'h00A5, 0, 82, PHASE_WORDS);
      // long blank wait, complementary duty bits, both sides idling
      run_phase(16'd1, 16'd1, 16'd7, 16'h005A, 34, 34, PHASE_WORDS);
      // full brightness with junk in the upper byte, no idling
      run_phase(16'd2, 16'd1, 16'd2, 16'hFFFF, 0, 0, PHASE_WORDS);
      // top delay values: the next step parks the scan for the rest of the run
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0080, 0, 0, 100);

      settle();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
design/mds_pkg.sv
design/multiplexed_digit_scanner.sv
test/mds_drive_checker.sv
test/multiplexed_digit_scanner_tb.sv
